/* rtl/core/pds_pkg.sv */
// Shared types and constants for the point distance statistics unit.
package pds_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 16;
    localparam int COUNT_W = 5;
    localparam int SUM_W   = 20;
    localparam int SQ_W    = 32;

    localparam logic [SUM_W-1:0]   SUM_MAX  = '1;
    localparam logic [COUNT_W-1:0] HITS_MAX = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX = 16'd46341;

    localparam logic REG_K_LOW  = 1'b0;
    localparam logic REG_K_HIGH = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } t_point;

    typedef struct packed {
        logic [DIST_W-1:0]  mean_distance;
        logic [DIST_W-1:0]  max_distance;
        logic [DIST_W-1:0]  min_distance;
        logic [COUNT_W-1:0] in_range_count;
    } t_stats;

endpackage

/* rtl/core/point_distance_statistics_unit.sv */
// Point distance statistics unit: distance of each point and per-set summary.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one point per
//   transaction, signed Q8.8 x and y. Output channel (o_out_valid /
//   i_out_ready / o_out_data) gives one summary after every NUM_POINTS-th
//   point: truncated mean, maximum, minimum and in-range count of the
//   distances, all unsigned Q8.8 but the count.
//   Each point passes through the states that square x and y in turn on the
//   shared 17x17 multiplier, a restoring square root that shifts two radicand
//   bits in and one root bit out per step, and an accumulate state, then
//   returns to idle; no new point is accepted until then. The last point of a
//   set adds a bit-serial division of the sum by NUM_POINTS and a state that
//   loads the output register.
//   The output register holds a finished summary while the receiver stalls;
//   points of the next set are accepted meanwhile, and a new summary waits
//   until the register is free.
//   Bounds k_low (address 0) and k_high (address 4) are to be written over
//   the APB port only while idle; the block itself does not enforce this.
//   Synchronous reset clears the set and the bounds to 0 and 0xFFFF.
module point_distance_statistics_unit
    import pds_pkg::*;
#(
    parameter int NUM_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_point      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_stats      o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(NUM_POINTS + 1);
    localparam int RW = $clog2(NUM_POINTS) + 1;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = SUM_W;
    localparam int AW = COORD_W + 1;
    localparam int RMW = DIST_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQX  = 3'd1;
    localparam logic [2:0] S_SQY  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]         r_state;
    logic [4:0]         r_cnt;
    logic [AW-1:0]      r_ax, r_ay;
    logic [SQ_W-1:0]    r_rad;
    logic [RMW-1:0]     r_rem;
    logic [DIST_W-1:0]  r_root;
    logic [PW-1:0]      r_seen;
    logic [SUM_W-1:0]   r_sum;
    logic [DIST_W-1:0]  r_max, r_min;
    logic [COUNT_W-1:0] r_hits;
    logic [SUM_W-1:0]   r_dq;
    logic [RW-1:0]      r_drem;
    logic [DIST_W-1:0]  r_klow, r_khigh;
    logic               r_out_valid;
    t_stats             r_out;

    logic [AW-1:0]      m_op;
    logic [2*AW-1:0]    m_prod;
    logic [RMW+1:0]     rem_sh;
    logic [RMW+1:0]     trial;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   n_sum;
    logic [DIST_W-1:0]  n_max, n_min;
    logic [COUNT_W-1:0] n_hits;
    logic [RW:0]        d_sh;
    logic               d_ge;
    logic               last_pt;
    logic               cfg_wr;

    assign m_op   = (r_state == S_SQX) ? r_ax : r_ay;
    assign m_prod = m_op * m_op;

    assign rem_sh = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};

    assign sum_ext = {1'b0, r_sum} + (SUM_W+1)'(r_root);
    assign n_sum   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    assign n_max   = (r_root > r_max) ? r_root : r_max;
    assign n_min   = (r_root < r_min) ? r_root : r_min;
    assign n_hits  = (r_root >= r_klow && r_root <= r_khigh && r_hits != HITS_MAX)
                   ? r_hits + 1'b1 : r_hits;
    assign last_pt = (r_seen == PW'(NUM_POINTS - 1));

    assign d_sh = {r_drem, r_dq[SUM_W-1]};
    assign d_ge = (d_sh >= (RW+1)'(NUM_POINTS));

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_K_HIGH) ? {16'b0, r_khigh} : {16'b0, r_klow};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klow  <= '0;
            r_khigh <= '1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_K_HIGH) begin
                r_khigh <= pwdata[DIST_W-1:0];
            end else begin
                r_klow <= pwdata[DIST_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_seen      <= '0;
            r_sum       <= '0;
            r_max       <= '0;
            r_min       <= '1;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ax    <= i_in_data.x_coord[COORD_W-1]
                                 ? AW'(-{i_in_data.x_coord[COORD_W-1], i_in_data.x_coord})
                                 : AW'({1'b0, i_in_data.x_coord});
                        r_ay    <= i_in_data.y_coord[COORD_W-1]
                                 ? AW'(-{i_in_data.y_coord[COORD_W-1], i_in_data.y_coord})
                                 : AW'({1'b0, i_in_data.y_coord});
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_rad   <= m_prod[SQ_W-1:0];
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_rad   <= r_rad + m_prod[SQ_W-1:0];
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_rad <= {r_rad[SQ_W-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        r_rem  <= RMW'(rem_sh - trial);
                        r_root <= {r_root[DIST_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh[RMW-1:0];
                        r_root <= {r_root[DIST_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(ROOT_STEPS - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum  <= n_sum;
                    r_max  <= n_max;
                    r_min  <= n_min;
                    r_hits <= n_hits;
                    r_seen <= r_seen + 1'b1;
                    r_dq   <= n_sum;
                    r_drem <= '0;
                    r_cnt  <= '0;
                    r_state <= last_pt ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    r_dq   <= {r_dq[SUM_W-2:0], d_ge};
                    r_drem <= d_ge ? RW'(d_sh - (RW+1)'(NUM_POINTS)) : d_sh[RW-1:0];
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.mean_distance  <= r_dq[DIST_W-1:0];
                        r_out.max_distance   <= r_max;
                        r_out.min_distance   <= r_min;
                        r_out.in_range_count <= r_hits;
                        r_out_valid <= 1'b1;
                        r_seen  <= '0;
                        r_sum   <= '0;
                        r_max   <= '0;
                        r_min   <= '1;
                        r_hits  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/pds_checker.sv */
// Port-level checks for the point distance statistics unit, with its bind.
module pds_checker
    import pds_pkg::*;
#(
    parameter int NUM_POINTS = 16
) (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   o_out_valid,
    input logic   i_out_ready,
    input t_stats o_out_data
);

    localparam int HIT_LIMIT = (NUM_POINTS < 31) ? NUM_POINTS : 31;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    a_min_mean_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.min_distance <= o_out_data.max_distance
                     && o_out_data.mean_distance <= o_out_data.max_distance
                     && o_out_data.max_distance <= DIST_MAX)
        else $error("summary distances out of order");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.in_range_count <= COUNT_W'(HIT_LIMIT))
        else $error("in-range count exceeds set size");

endmodule

bind point_distance_statistics_unit pds_checker #(
    .NUM_POINTS(NUM_POINTS)
) u_pds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
